### sv/jsu_pkg.sv
// Shared types and result codes for the JSON string unescaper.
package jsu_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes carried with an error result; ERR_NONE goes with every other result.
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_NO_OPEN      = 2'd0;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
  localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd2;
  localparam logic [1:0] ERR_BAD_HEX      = 2'd3;

  // At most three results per input byte; the output queue holds four.
  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;
  } out_t;

  // Results produced by one input byte, first result in item[0].
  typedef struct packed {
    logic [1:0]              n;
    out_t [MaxRes-1:0]       item;
  } res_t;

endpackage

### sv/json_string_unescape.sv
// Top level of the JSON string unescaper: byte decode feeding a result queue.
//
//   channel  direction  payload           handshake
//   in_      input      jsu_pkg::in_t     in_valid / in_ready
//   out_     output     jsu_pkg::out_t    out_valid / out_ready
//
// One input byte is taken per cycle while in_ready is high; its results are ready in the next cycle.
// A \u escape whose code needs three UTF-8 bytes yields three results; the
// four-entry result queue absorbs such bursts, and the sustained rate is one
// result per cycle at the output register while out_ready is high.
// in_ready depends only on queue occupancy, never combinationally on out_ready.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the queue.
module json_string_unescape (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  jsu_pkg::res_t res;
  logic          acc;

  assign acc = in_valid && in_ready;

  jsu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_item (in_data),
    .res     (res)
  );

  jsu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .res       (res),
    .push_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A request that produced results must show a result on the next cycle.
  a_res_appears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.n != 2'd0 |=> out_valid)
    else $error("results of an accepted request did not reach the output");

  // Close and error results always end their request.
  a_nonbyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != jsu_pkg::KIND_BYTE |-> out_data.last)
    else $error("close or error result without last");

  // Close and error results carry a zero byte.
  a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != jsu_pkg::KIND_BYTE |-> out_data.out_byte == 8'h00)
    else $error("close or error result with non-zero byte");

  // Input is only held off while results are waiting.
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result queue");

endmodule

### sv/jsu_ctrl.sv
// Parser state and per-byte decode of escapes and UTF-8 encoding.
module jsu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  jsu_pkg::in_t  in_item,
  output jsu_pkg::res_t res
);

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_TEXT = 2'd1,
    M_ESC  = 2'd2,
    M_HEX  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] LIMIT_ONE  = 16'h0080;
  localparam logic [15:0] LIMIT_TWO  = 16'h0800;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_accum_r, code_accum_nxt;

  logic [7:0]  b;
  logic        eoi;
  logic [4:0]  hv;
  logic [15:0] code;
  logic [7:0]  esc_val;
  logic        esc_ok;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic jsu_pkg::out_t mk(input logic [1:0] kind, input logic [7:0] ob,
                                       input logic [1:0] err, input logic lst);
    jsu_pkg::out_t o;
    o.kind       = kind;
    o.out_byte   = ob;
    o.error_code = err;
    o.last       = lst;
    return o;
  endfunction

  assign b    = in_item.in_byte;
  assign eoi  = in_item.end_of_input;
  assign hv   = hex_digit(b);
  assign code = {code_accum_r[11:0], hv[3:0]};

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = '0;
    case (b)
      CH_QUOTE:  esc_val = 8'h22;
      CH_BSLASH: esc_val = 8'h5C;
      CH_SLASH:  esc_val = 8'h2F;
      CH_B:      esc_val = 8'h08;
      CH_F:      esc_val = 8'h0C;
      CH_N:      esc_val = 8'h0A;
      CH_R:      esc_val = 8'h0D;
      CH_T:      esc_val = 8'h09;
      default:   esc_ok  = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    hex_count_nxt  = hex_count_r;
    code_accum_nxt = code_accum_r;
    res            = '0;
    unique case (mode_r)
      M_IDLE: begin
        if (eoi || b != CH_QUOTE) begin
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_ERROR, 8'h00, jsu_pkg::ERR_NO_OPEN, 1'b1);
        end else begin
          mode_nxt = M_TEXT;
        end
      end
      M_TEXT: begin
        if (eoi) begin
          mode_nxt    = M_IDLE;
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_ERROR, 8'h00, jsu_pkg::ERR_UNTERMINATED, 1'b1);
        end else if (b == CH_QUOTE) begin
          mode_nxt    = M_IDLE;
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_NONE, 1'b1);
        end else if (b == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE, 1'b1);
        end
      end
      M_ESC: begin
        if (!eoi && b == CH_U) begin
          mode_nxt       = M_HEX;
          hex_count_nxt  = '0;
          code_accum_nxt = '0;
        end else if (!eoi && esc_ok) begin
          mode_nxt    = M_TEXT;
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_BYTE, esc_val, jsu_pkg::ERR_NONE, 1'b1);
        end else begin
          mode_nxt    = M_IDLE;
          res.n       = 2'd1;
          res.item[0] = mk(jsu_pkg::KIND_ERROR, 8'h00, jsu_pkg::ERR_BAD_ESCAPE, 1'b1);
        end
      end
      M_HEX: begin
        if (eoi || !hv[4]) begin
          mode_nxt       = M_IDLE;
          hex_count_nxt  = '0;
          code_accum_nxt = '0;
          res.n          = 2'd1;
          res.item[0]    = mk(jsu_pkg::KIND_ERROR, 8'h00, jsu_pkg::ERR_BAD_HEX, 1'b1);
        end else if (hex_count_r != 2'd3) begin
          code_accum_nxt = code;
          hex_count_nxt  = hex_count_r + 2'd1;
        end else begin
          // Fourth digit: encode the gathered code point as UTF-8.
          mode_nxt       = M_TEXT;
          hex_count_nxt  = '0;
          code_accum_nxt = '0;
          if (code < LIMIT_ONE) begin
            res.n       = 2'd1;
            res.item[0] = mk(jsu_pkg::KIND_BYTE, code[7:0], jsu_pkg::ERR_NONE, 1'b1);
          end else if (code < LIMIT_TWO) begin
            res.n       = 2'd2;
            res.item[0] = mk(jsu_pkg::KIND_BYTE, UTF8_LEAD2 | {3'b000, code[10:6]},
                             jsu_pkg::ERR_NONE, 1'b0);
            res.item[1] = mk(jsu_pkg::KIND_BYTE, UTF8_CONT | {2'b00, code[5:0]},
                             jsu_pkg::ERR_NONE, 1'b1);
          end else begin
            res.n       = 2'd3;
            res.item[0] = mk(jsu_pkg::KIND_BYTE, UTF8_LEAD3 | {4'b0000, code[15:12]},
                             jsu_pkg::ERR_NONE, 1'b0);
            res.item[1] = mk(jsu_pkg::KIND_BYTE, UTF8_CONT | {2'b00, code[11:6]},
                             jsu_pkg::ERR_NONE, 1'b0);
            res.item[2] = mk(jsu_pkg::KIND_BYTE, UTF8_CONT | {2'b00, code[5:0]},
                             jsu_pkg::ERR_NONE, 1'b1);
          end
        end
      end
      default: mode_nxt = M_IDLE;
    endcase
    // Every return to idle clears the escape gathering state.
    if (mode_nxt == M_IDLE) begin
      hex_count_nxt  = '0;
      code_accum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      hex_count_r  <= '0;
      code_accum_r <= '0;
    end else if (acc) begin
      mode_r       <= mode_nxt;
      hex_count_r  <= hex_count_nxt;
      code_accum_r <= code_accum_nxt;
    end
  end

endmodule

### sv/jsu_outq.sv
// Four-entry shifting result queue; the head entry is the output register.
module jsu_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jsu_pkg::res_t  res,
  output logic           push_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::out_t  out_data
);

  localparam int unsigned CW = $clog2(jsu_pkg::QDepth + 1);

  jsu_pkg::out_t [jsu_pkg::QDepth-1:0] slot_r, slot_nxt, shifted;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] base;
  logic [CW-1:0] off;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[0];
  // Room for a full three-result request whatever happens at the output.
  assign push_ok   = (count_r <= CW'(jsu_pkg::QDepth - jsu_pkg::MaxRes));

  always_comb begin
    shifted[jsu_pkg::QDepth-1] = slot_r[jsu_pkg::QDepth-1];
    for (int i = 0; i < jsu_pkg::QDepth - 1; i++) begin
      shifted[i] = slot_r[i+1];
    end
  end

  always_comb begin
    base      = count_r - CW'(pop);
    count_nxt = base + (push ? CW'(res.n) : '0);
    slot_nxt  = slot_r;
    off       = '0;
    for (int i = 0; i < jsu_pkg::QDepth; i++) begin
      off = CW'(i) - base;
      if (CW'(i) < base) begin
        slot_nxt[i] = pop ? shifted[i] : slot_r[i];
      end else if (push && off < CW'(res.n)) begin
        slot_nxt[i] = res.item[off[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    slot_r <= slot_nxt;
  end

endmodule

### bench/unescape_checker.sv
// Channel monitor for the JSON string unescaper: predicts every result and compares it.
`timescale 1ns / 1ps
module unescape_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  jsu_pkg::out_t out_data,
  output int unsigned   faults,
  output int unsigned   pending,
  output int unsigned   results_seen
);

  typedef enum logic [1:0] {PS_IDLE, PS_TEXT, PS_ESC, PS_HEX} parse_state_t;

  localparam logic [1:0] LastDigit = 2'd3;
  localparam logic [7:0] Quote     = 8'h22;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam int unsigned PrintCap = 40;

  parse_state_t  state;
  logic [1:0]    digits;
  logic [15:0]   code_acc;
  jsu_pkg::out_t decoded_q[$];

  task automatic report_mismatch(string what);
    if (faults < PrintCap) $display("[%0t] mismatch: %s", $time, what);
    faults++;
  endtask

  function automatic void clear_parser();
    state    = PS_IDLE;
    digits   = '0;
    code_acc = '0;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] code);
    jsu_pkg::out_t r;
    r.kind       = kind;
    r.out_byte   = data;
    r.error_code = code;
    r.last       = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic void fail_to_idle(logic [1:0] code);
    clear_parser();
    emit(jsu_pkg::KIND_ERROR, 8'h00, code);
  endfunction

  // Appends the results that one accepted request should cause.
  function automatic void predict_unescape(jsu_pkg::in_t req);
    int unsigned   queued_at_start;
    logic [7:0]    b;
    logic [7:0]    v;
    logic [3:0]    nib;
    logic          known;
    logic [15:0]   code;
    jsu_pkg::out_t tail;
    queued_at_start = decoded_q.size();
    b      = req.in_byte;
    v      = 8'h00;
    nib    = '0;
    known  = 1'b1;
    case (state)
      PS_IDLE: begin
        if (req.end_of_input || b != Quote) fail_to_idle(jsu_pkg::ERR_NO_OPEN);
        else state = PS_TEXT;
      end
      PS_TEXT: begin
        if (req.end_of_input) begin
          fail_to_idle(jsu_pkg::ERR_UNTERMINATED);
        end else if (b == Quote) begin
          clear_parser();
          emit(jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_NONE);
        end else if (b == Backslash) begin
          state = PS_ESC;
        end else begin
          emit(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE);
        end
      end
      PS_ESC: begin
        if (req.end_of_input) begin
          fail_to_idle(jsu_pkg::ERR_BAD_ESCAPE);
        end else if (b == "u") begin
          state    = PS_HEX;
          digits   = '0;
          code_acc = '0;
        end else begin
          case (b)
            Quote, Backslash, "/": v = b;
            "b":     v = 8'h08;
            "f":     v = 8'h0C;
            "n":     v = 8'h0A;
            "r":     v = 8'h0D;
            "t":     v = 8'h09;
            default: known = 1'b0;
          endcase
          if (known) begin
            state = PS_TEXT;
            emit(jsu_pkg::KIND_BYTE, v, jsu_pkg::ERR_NONE);
          end else begin
            fail_to_idle(jsu_pkg::ERR_BAD_ESCAPE);
          end
        end
      end
      default: begin
        // Letters carry their value minus nine in the low nibble, in either case.
        if (b >= "0" && b <= "9") nib = b[3:0];
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) nib = b[3:0] + 4'd9;
        else known = 1'b0;
        if (req.end_of_input || !known) begin
          fail_to_idle(jsu_pkg::ERR_BAD_HEX);
        end else begin
          code = {code_acc[11:0], nib};
          if (digits != LastDigit) begin
            code_acc = code;
            digits   = digits + 2'd1;
          end else begin
            state    = PS_TEXT;
            digits   = '0;
            code_acc = '0;
            if (code < 16'h0080) begin
              emit(jsu_pkg::KIND_BYTE, code[7:0], jsu_pkg::ERR_NONE);
            end else if (code < 16'h0800) begin
              emit(jsu_pkg::KIND_BYTE, {3'b110, code[10:6]}, jsu_pkg::ERR_NONE);
              emit(jsu_pkg::KIND_BYTE, {2'b10, code[5:0]}, jsu_pkg::ERR_NONE);
            end else begin
              emit(jsu_pkg::KIND_BYTE, {4'b1110, code[15:12]}, jsu_pkg::ERR_NONE);
              emit(jsu_pkg::KIND_BYTE, {2'b10, code[11:6]}, jsu_pkg::ERR_NONE);
              emit(jsu_pkg::KIND_BYTE, {2'b10, code[5:0]}, jsu_pkg::ERR_NONE);
            end
          end
        end
      end
    endcase
    if (decoded_q.size() > queued_at_start) begin
      tail      = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.insert(decoded_q.size(), tail);
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    jsu_pkg::out_t want;
    if (!rst_n) begin
      clear_parser();
      decoded_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) predict_unescape(in_data);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing awaited: kind %0d byte %02h",
                                    results_seen, out_data.kind, out_data.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      results_seen, out_data.kind, want.kind));
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("result %0d byte %02h, expected %02h",
                                      results_seen, out_data.out_byte, want.out_byte));
          if (out_data.error_code !== want.error_code)
            report_mismatch($sformatf("result %0d error code %0d, expected %0d",
                                      results_seen, out_data.error_code, want.error_code));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                      results_seen, out_data.last, want.last));
        end
        results_seen++;
      end
      pending <= decoded_q.size();
    end
  end

endmodule

### bench/tb_top.sv
// Top of the unescaper bench: clock, reset, request stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned RandomItems  = 480;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned IdlePct      = 20;
  localparam logic [7:0]  Quote        = 8'h22;
  localparam logic [7:0]  Backslash    = 8'h5C;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  jsu_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  jsu_pkg::out_t out_data;
  int unsigned   faults;
  int unsigned   pending;
  int unsigned   results_seen;
  int unsigned   idle_pct;
  int unsigned   bytes_sent;
  int unsigned   strings_sent;
  jsu_pkg::in_t  script_q[$];

  json_string_unescape i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  unescape_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .faults       (faults),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  function automatic void add_request(jsu_pkg::in_t req);
    script_q.insert(script_q.size(), req);
  endfunction

  function automatic jsu_pkg::in_t text_byte(logic [7:0] b);
    return '{in_byte: b, end_of_input: 1'b0};
  endfunction

  // The byte that travels with an end of input is ignored, so it is random.
  function automatic jsu_pkg::in_t input_end();
    return '{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1};
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) add_request(text_byte(s[i]));
  endfunction

  // Letters come out in upper or lower case at random.
  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return {4'h3, nib};
    return {($urandom_range(1) != 0) ? 4'h4 : 4'h6, nib - 4'd9};
  endfunction

  function automatic void queue_hex(logic [15:0] code);
    for (int i = 3; i >= 0; i--) add_request(text_byte(hex_char(code[i*4 +: 4])));
  endfunction

  // Mostly well-formed strings with random content; a fifth end broken in some way.
  function automatic void queue_random_string();
    logic [7:0]  b;
    int unsigned pick;
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1) == 0) begin
        add_request(input_end());
      end else begin
        do b = 8'($urandom_range(255)); while (b == Quote);
        add_request(text_byte(b));
      end
    end
    queue_text("\"");
    repeat ($urandom_range(10)) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        do b = 8'($urandom_range(255)); while (b == Quote || b == Backslash);
        add_request(text_byte(b));
      end else if (pick < 75) begin
        case ($urandom_range(7))
          0:       b = Quote;
          1:       b = Backslash;
          2:       b = "/";
          3:       b = "b";
          4:       b = "f";
          5:       b = "n";
          6:       b = "r";
          default: b = "t";
        endcase
        add_request(text_byte(Backslash));
        add_request(text_byte(b));
      end else begin
        queue_text("\\u");
        case ($urandom_range(2))
          0:       queue_hex(16'($urandom_range(16'h007F)));
          1:       queue_hex(16'($urandom_range(16'h07FF, 16'h0080)));
          default: queue_hex(16'($urandom_range(16'hFFFF, 16'h0800)));
        endcase
      end
    end
    pick = $urandom_range(99);
    if (pick < 80) begin
      queue_text("\"");
    end else if (pick < 84) begin
      add_request(input_end());
    end else if (pick < 88) begin
      queue_text("\\");
      add_request(input_end());
    end else if (pick < 92) begin
      do b = 8'($urandom_range(255));
      while (b inside {Quote, Backslash, "/", "b", "f", "n", "r", "t", "u"});
      add_request(text_byte(Backslash));
      add_request(text_byte(b));
    end else begin
      queue_text("\\u");
      repeat ($urandom_range(3)) add_request(text_byte(hex_char(4'($urandom_range(15)))));
      if (pick < 96) begin
        add_request(input_end());
      end else begin
        do b = 8'($urandom_range(255)); while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
        add_request(text_byte(b));
      end
    end
    strings_sent++;
  endfunction

  task automatic send_request(jsu_pkg::in_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic play_script();
    while (script_q.size() != 0) send_request(script_q.pop_front());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned random_start;
    bit          drained_mid;
    drained_mid = 1'b0;
    idle_pct    = IdlePct;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Stray bytes while idle, the second flagged as end of input.
    add_request(text_byte(8'h00));
    add_request('{in_byte: 8'hFF, end_of_input: 1'b1});
    // A closed string holding a zero code, a surrogate code and a raw top byte.
    queue_text("\"\\u");
    queue_hex(16'h0000);
    queue_text("\\u");
    queue_hex(16'hDBFF);
    add_request(text_byte(8'hFF));
    queue_text("\"");
    // One string for each way of breaking off.
    queue_text("\"\\q");
    queue_text("\"\\ug");
    queue_text("\"");
    add_request(input_end());
    queue_text("\"\\");
    add_request(input_end());
    queue_text("\"\\u");
    add_request(input_end());
    strings_sent += 6;
    play_script();
    drain_results();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomItems) begin
      idle_pct = (bytes_sent - random_start >= 200 && bytes_sent - random_start < 320) ?
                 0 : IdlePct;
      if (!drained_mid && bytes_sent - random_start >= 350) begin
        drain_results();
        drained_mid = 1'b1;
      end
      queue_random_string();
      play_script();
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d bytes in %0d strings: corner cases, then random text and escapes",
             bytes_sent, strings_sent);
    $display("with broken endings; %0d results compared, %0d mismatches.",
             results_seen, faults);
    if (faults == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timed out with %0d results still awaited.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
sv/jsu_pkg.sv
sv/jsu_ctrl.sv
sv/jsu_outq.sv
sv/json_string_unescape.sv
bench/unescape_checker.sv
bench/tb_top.sv
